// File: sv/nfba_pkg.sv
package nfba_pkg;

    // Bitmap row geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int CH_W   = 16;
    localparam int REG_W  = 32;

    // Operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_CLAIM   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Register index (paddr bit 2)
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    // Masking context for one bitmap row
    typedef struct packed {
        logic             use_start;
        logic [BIT_W-1:0] start_bit;
        logic             at_last;
        logic [BIT_W-1:0] last_bit;
    } t_scan_ctl;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } t_scan_res;

endpackage

// File: sv/nfba_row_scan.sv
module nfba_row_scan
    import nfba_pkg::*;
(
    input  logic [WORD_W-1:0] i_row_bits,
    input  t_scan_ctl         i_ctl,
    output t_scan_res         o_res
);

    logic [WORD_W-1:0] w_hi_mask;
    logic [WORD_W-1:0] w_lo_mask;
    logic [WORD_W-1:0] w_free;

    // Keep bits from the start bit up to the last bit of the span, then pick the lowest free one
    always_comb begin
        w_hi_mask = i_ctl.at_last ?
                    ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - i_ctl.last_bit)) :
                    {WORD_W{1'b1}};
        w_lo_mask = i_ctl.use_start ? ({WORD_W{1'b1}} << i_ctl.start_bit) : {WORD_W{1'b1}};
        w_free    = ~i_row_bits & w_hi_mask & w_lo_mask;
        o_res.hit     = |w_free;
        o_res.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                o_res.bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

// File: sv/next_fit_bitmap_channel_allocator.sv
// Claim and release pass through S_READ, S_CHECK and S_DONE before the output register presents
// the result (o_out_valid high); allocate repeats S_READ and S_CHECK for each bitmap row examined
// (32 channels per row, at most ROWS + 1 rows examined). Items that fail on span, range or code checks
// go straight from S_IDLE to S_DONE. A new item is taken only in S_IDLE, after the previous result has
// left S_DONE; one bitmap read per row examined, at most one bitmap write per item.
// Reset (synchronous, active low) restores range_low = 1, range_high = 2047 and runs a clearing
// pass over all ROWS rows (64 at MAX_CHANNELS = 2048); each register write repeats that pass.
module next_fit_bitmap_channel_allocator
    import nfba_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // Input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_operation,
    input  logic [CH_W-1:0]  i_channel,

    // Output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_success,
    output logic [CH_W-1:0]  o_granted_channel,

    // Configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [REG_W-1:0] pwdata,
    output logic [REG_W-1:0] prdata,
    output logic             pready
);

    // Bitmap geometry: rows of WORD_W channels, position = {row, bit}
    localparam int ROWS  = (MAX_CHANNELS + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = $clog2(MAX_CHANNELS);
    localparam int X_W   = ROW_W + BIT_W;

    // Control and configuration registers
    t_state              r_state, n_state;
    logic [CH_W-1:0]     r_low, n_low;
    logic [CH_W-1:0]     r_high, n_high;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ROW_W-1:0]    r_clr_row, n_clr_row;
    logic                r_out_valid, n_out_valid;

    // Item context and result
    logic [1:0]          r_op, n_op;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic                r_phase, n_phase;
    logic                r_res_ok, n_res_ok;
    logic [CH_W-1:0]     r_res_grant, n_res_grant;
    logic                r_out_ok, n_out_ok;
    logic [CH_W-1:0]     r_out_grant, n_out_grant;

    // Bitmap RAM: one set bit per channel in use
    logic [WORD_W-1:0]   r_map [ROWS];
    logic [WORD_W-1:0]   r_rdata;
    logic                w_rd_en;
    logic                w_wr_en;
    logic [ROW_W-1:0]    w_wr_row;
    logic [WORD_W-1:0]   w_wr_data;

    // Span and position decode
    logic [CH_W-1:0]     w_nm1;
    logic                w_span_ok;
    logic [X_W-1:0]      w_last_x;
    logic [ROW_W-1:0]    w_last_row;
    logic [X_W-1:0]      w_pos_x;
    logic [ROW_W-1:0]    w_pos_row;
    logic                w_pos_ok;
    logic [CH_W-1:0]     w_in_off;
    logic [X_W-1:0]      w_in_off_x;
    logic                w_in_range;
    logic                w_in_fail;

    logic                w_cfg_wr;
    logic                w_accept;
    logic                w_out_free;
    logic                w_at_last;
    logic                w_miss_end;
    logic [X_W-1:0]      w_found_x;
    logic [WORD_W-1:0]   w_bit_mask;
    logic [WORD_W-1:0]   w_found_mask;

    t_scan_ctl           w_scan_ctl;
    t_scan_res           w_scan_res;

    // Usable span is range_low..range_high, at most MAX_CHANNELS wide
    assign w_nm1      = r_high - r_low;
    assign w_span_ok  = (r_high >= r_low) && (w_nm1 <= CH_W'(MAX_CHANNELS - 1));
    assign w_last_x   = w_nm1[X_W-1:0];
    assign w_last_row = w_last_x[X_W-1:BIT_W];

    assign w_pos_x    = X_W'(r_pos);
    assign w_pos_row  = w_pos_x[X_W-1:BIT_W];
    assign w_pos_ok   = CH_W'(r_pos) <= w_nm1;

    assign w_in_off   = i_channel - r_low;
    assign w_in_off_x = w_in_off[X_W-1:0];
    assign w_in_range = w_span_ok && (i_channel >= r_low) && (i_channel <= r_high);

    // Fail at once on a bad span, an unknown code, or a claim/release outside the span
    always_comb begin
        w_in_fail = 1'b1;
        if (w_span_ok) begin
            case (i_operation)
                OP_ALLOC:             w_in_fail = 1'b0;
                OP_CLAIM, OP_RELEASE: w_in_fail = !w_in_range;
                default:              w_in_fail = 1'b1;
            endcase
        end
    end

    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Row scan: the wrap pass ends at the saved row or at the last row of the span
    assign w_at_last  = (r_row == w_last_row);
    assign w_miss_end = r_phase && (w_at_last || (r_row == w_pos_row));

    always_comb begin
        w_scan_ctl.use_start = !r_phase && (r_row == w_pos_row);
        w_scan_ctl.start_bit = w_pos_x[BIT_W-1:0];
        w_scan_ctl.at_last   = w_at_last;
        w_scan_ctl.last_bit  = w_last_x[BIT_W-1:0];
    end

    nfba_row_scan u_row_scan (
        .i_row_bits (r_rdata),
        .i_ctl      (w_scan_ctl),
        .o_res      (w_scan_res)
    );

    assign w_found_x    = {r_row, w_scan_res.bit_idx};
    assign w_bit_mask   = {{(WORD_W - 1){1'b0}}, 1'b1} << r_bit;
    assign w_found_mask = {{(WORD_W - 1){1'b0}}, 1'b1} << w_scan_res.bit_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_fail ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((r_op == OP_ALLOC) && !w_scan_res.hit && !w_miss_end) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // Restart the clearing pass on any register write
        if (w_cfg_wr) begin
            n_state = S_CLEAR;
        end
    end

    // RAM strobes
    always_comb begin
        w_rd_en   = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_row  = r_row;
        w_wr_data = r_rdata;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_row  = r_clr_row;
                w_wr_data = '0;
            end
            S_READ: begin
                w_rd_en = 1'b1;
            end
            S_CHECK: begin
                case (r_op)
                    OP_ALLOC: begin
                        w_wr_en   = w_scan_res.hit;
                        w_wr_data = r_rdata | w_found_mask;
                    end
                    OP_CLAIM: begin
                        w_wr_en   = !r_rdata[r_bit];
                        w_wr_data = r_rdata | w_bit_mask;
                    end
                    OP_RELEASE: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = r_rdata & ~w_bit_mask;
                    end
                    default: begin
                        w_wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_low       = r_low;
        n_high      = r_high;
        n_pos       = r_pos;
        n_clr_row   = r_clr_row;
        n_op        = r_op;
        n_row       = r_row;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_res_ok    = r_res_ok;
        n_res_grant = r_res_grant;
        n_out_ok    = r_out_ok;
        n_out_grant = r_out_grant;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + ROW_W'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op        = i_operation;
                    n_res_ok    = 1'b0;
                    n_res_grant = i_channel;
                    if (i_operation == OP_ALLOC) begin
                        // Start at the saved row, or go straight to the wrap pass
                        n_row   = w_pos_ok ? w_pos_row : '0;
                        n_phase = !w_pos_ok;
                    end else begin
                        n_row   = w_in_off_x[X_W-1:BIT_W];
                        n_bit   = w_in_off_x[BIT_W-1:0];
                        n_phase = 1'b0;
                    end
                end
            end
            S_CHECK: begin
                case (r_op)
                    OP_ALLOC: begin
                        if (w_scan_res.hit) begin
                            n_pos       = POS_W'(w_found_x);
                            n_res_ok    = 1'b1;
                            n_res_grant = r_low + CH_W'(w_found_x);
                        end else if (!w_miss_end) begin
                            if (!r_phase && w_at_last) begin
                                n_row   = '0;
                                n_phase = 1'b1;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end
                    end
                    OP_CLAIM: begin
                        n_res_ok = !r_rdata[r_bit];
                    end
                    OP_RELEASE: begin
                        n_res_ok = 1'b1;
                    end
                    default: begin
                        n_res_ok = 1'b0;
                    end
                endcase
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_grant = r_res_grant;
                end
            end
            default: begin
                n_out_ok = r_out_ok;
            end
        endcase

        if (w_cfg_wr) begin
            if (paddr[2] == REG_RANGE_HIGH) begin
                n_high = pwdata[CH_W-1:0];
            end else begin
                n_low = pwdata[CH_W-1:0];
            end
            n_pos     = '0;
            n_clr_row = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_low       <= CH_W'(1);
            r_high      <= CH_W'(2047);
            r_pos       <= '0;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_high      <= n_high;
            r_pos       <= n_pos;
            r_clr_row   <= n_clr_row;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_row       <= n_row;
        r_bit       <= n_bit;
        r_phase     <= n_phase;
        r_res_ok    <= n_res_ok;
        r_res_grant <= n_res_grant;
        r_out_ok    <= n_out_ok;
        r_out_grant <= n_out_grant;
    end

    // Bitmap RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_map[w_wr_row] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_map[r_row];
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_success         = r_out_ok;
    assign o_granted_channel = r_out_grant;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RANGE_HIGH) ? REG_W'(r_high) : REG_W'(r_low);

endmodule
